// ----- sv/mct_pkg.sv -----
`timescale 1ns / 1ps

package mct_pkg;

    localparam int MCT_BUTTONS    = 16;
    localparam int MCT_BUTTON_W   = 4;
    localparam int MCT_MAX_SLOTS  = 1 << MCT_BUTTON_W;
    localparam logic [31:0] MCT_TAP_WINDOW_RST = 32'd250000000;

    // item kinds
    localparam logic [2:0] KIND_PRESS   = 3'd0;
    localparam logic [2:0] KIND_RELEASE = 3'd1;
    localparam logic [2:0] KIND_POLL    = 3'd2;
    localparam logic [2:0] KIND_CLEAR   = 3'd3;
    localparam logic [2:0] KIND_LATCH   = 3'd4;

    // result actions
    localparam logic [1:0] ACT_DOWN   = 2'd0;
    localparam logic [1:0] ACT_UP     = 2'd1;
    localparam logic [1:0] ACT_REPEAT = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    // tap phases
    localparam logic [2:0] PH_NONE    = 3'd0;
    localparam logic [2:0] PH_PENDING = 3'd1;
    localparam logic [2:0] PH_SINGLE  = 3'd2;
    localparam logic [2:0] PH_DOUBLE  = 3'd3;
    localparam logic [2:0] PH_TRIPLE  = 3'd4;

    localparam logic [7:0] TAP_MAX = 8'hFF;

    typedef struct packed {
        logic [63:0] press_stamp;
        logic [63:0] release_stamp;
        logic [63:0] window_end;
        logic [63:0] hold_length;
        logic [7:0]  click_count;
        logic [3:0]  press_mods;
        logic        latch;
        logic        held;
        logic        released;
    } t_slot;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  tap_count;
        logic [2:0]  tap_phase;
        logic        pressed;
        logic [63:0] hold_now;
        logic [63:0] last_hold;
        logic        press_latch;
    } t_result;

    // slots actually addressable by a 4-bit button field
    function automatic int mct_slots(input int buttons);
        return (buttons < MCT_MAX_SLOTS) ? buttons : MCT_MAX_SLOTS;
    endfunction

    function automatic int mct_idx_w(input int slots);
        return (slots > 1) ? $clog2(slots) : 1;
    endfunction

endpackage

// ----- sv/mct_slot_table.sv -----
`timescale 1ns / 1ps

module mct_slot_table #(
    parameter int BUTTONS = mct_pkg::MCT_BUTTONS
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic [mct_pkg::mct_idx_w(mct_pkg::mct_slots(BUTTONS))-1:0] i_rd_idx,
    output mct_pkg::t_slot                                      o_rd_slot,
    input  logic                                                i_wr_en,
    input  logic [mct_pkg::mct_idx_w(mct_pkg::mct_slots(BUTTONS))-1:0] i_wr_idx,
    input  mct_pkg::t_slot                                      i_wr_slot
);
    import mct_pkg::*;

    localparam int SLOTS = mct_slots(BUTTONS);

    t_slot r_slots [SLOTS];

    assign o_rd_slot = r_slots[i_rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_slots[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_slots[i_wr_idx] <= i_wr_slot;
        end
    end

endmodule

// ----- sv/mct_update.sv -----
`timescale 1ns / 1ps

module mct_update #(
    parameter int BUTTONS = mct_pkg::MCT_BUTTONS
) (
    input  logic [2:0]      i_kind,
    input  logic [3:0]      i_button,
    input  logic [63:0]     i_now,
    input  logic [3:0]      i_mods,
    input  logic            i_latch_value,
    input  logic [31:0]     i_tap_window,
    input  mct_pkg::t_slot  i_slot,
    output mct_pkg::t_slot  o_slot,
    output logic            o_wr_en,
    output mct_pkg::t_result o_result
);
    import mct_pkg::*;

    logic        in_range;
    logic [63:0] since_release;
    logic [63:0] since_press;
    logic [64:0] win_sum;
    logic        tap_hit;
    logic        new_press;
    logic        pending;
    logic [1:0]  action;
    t_slot       n_slot;

    assign in_range      = (int'(i_button) < BUTTONS);
    assign since_release = i_now - i_slot.release_stamp;
    assign since_press   = i_now - i_slot.press_stamp;
    assign win_sum       = {1'b0, i_now} + {33'd0, i_tap_window};
    assign tap_hit       = i_slot.released && (since_release < {32'd0, i_tap_window})
                           && (i_slot.press_mods == i_mods);

    always_comb begin
        n_slot    = i_slot;
        action    = ACT_NONE;
        new_press = 1'b0;
        unique case (i_kind)
            KIND_PRESS: begin
                if (i_slot.held) begin
                    action = ACT_REPEAT;
                end else begin
                    new_press = 1'b1;
                    if (tap_hit) begin
                        if (i_slot.click_count != TAP_MAX) begin
                            n_slot.click_count = i_slot.click_count + 8'd1;
                        end
                    end else begin
                        n_slot.click_count = 8'd1;
                    end
                    n_slot.press_mods  = i_mods;
                    n_slot.window_end  = win_sum[63:0];
                    n_slot.press_stamp = i_now;
                    n_slot.held        = 1'b1;
                    action             = ACT_DOWN;
                end
            end
            KIND_RELEASE: begin
                if (i_slot.held) begin
                    n_slot.hold_length = since_press;
                end
                n_slot.release_stamp = i_now;
                n_slot.released      = 1'b1;
                n_slot.held          = 1'b0;
                n_slot.latch         = 1'b0;
                action               = ACT_UP;
            end
            KIND_CLEAR: n_slot.click_count = 8'd0;
            KIND_LATCH: n_slot.latch = i_latch_value;
            default: ;
        endcase
    end

    // new press: now < now + window exactly when the window is nonzero and the sum does not wrap
    assign pending = new_press ? ((i_tap_window != 32'd0) && !win_sum[64])
                               : (i_now < i_slot.window_end);

    always_comb begin
        o_result = '0;
        o_result.action = ACT_NONE;
        if (in_range) begin
            o_result.action      = action;
            o_result.tap_count   = n_slot.click_count;
            o_result.pressed     = n_slot.held;
            o_result.hold_now    = (n_slot.held && !new_press) ? since_press : 64'd0;
            o_result.last_hold   = n_slot.hold_length;
            o_result.press_latch = n_slot.latch;
            if (n_slot.click_count == 8'd0) begin
                o_result.tap_phase = PH_NONE;
            end else if (pending) begin
                o_result.tap_phase = PH_PENDING;
            end else if (n_slot.click_count >= 8'd3) begin
                o_result.tap_phase = PH_TRIPLE;
            end else if (n_slot.click_count == 8'd2) begin
                o_result.tap_phase = PH_DOUBLE;
            end else begin
                o_result.tap_phase = PH_SINGLE;
            end
        end
    end

    assign o_slot  = n_slot;
    assign o_wr_en = in_range;

endmodule

// ----- sv/button_multi_click_tracker.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_kind i_button i_now i_mods i_latch_value
// out       output     o_out_valid / i_out_ready  o_action_out o_button_out o_mods_out
//                                                 o_tap_count o_tap_phase o_is_pressed
//                                                 o_hold_now o_last_hold o_press_latch
// cfg       input      i_cfg_we (no wait)         i_cfg_wdata -> tap_window
//
// One transfer per cycle sustained while i_out_ready is high; an input transfer is
// registered in the input register, then in the result register.
// The slot read-modify-write is done combinationally from the input register, so the
// next item sees the updated slot directly and needs no forwarding.
// Reset (synchronous, active low) clears all slots, both valid flags and sets
// tap_window to 250 ms. A stalled result register holds the input stage too.
module button_multi_click_tracker #(
    parameter int BUTTONS = mct_pkg::MCT_BUTTONS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_kind,
    input  logic [3:0]  i_button,
    input  logic [63:0] i_now,
    input  logic [3:0]  i_mods,
    input  logic        i_latch_value,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_action_out,
    output logic [3:0]  o_button_out,
    output logic [3:0]  o_mods_out,
    output logic [7:0]  o_tap_count,
    output logic [2:0]  o_tap_phase,
    output logic        o_is_pressed,
    output logic [63:0] o_hold_now,
    output logic [63:0] o_last_hold,
    output logic        o_press_latch
);
    import mct_pkg::*;

    localparam int IDX_W = mct_idx_w(mct_slots(BUTTONS));

    // config register
    logic [31:0] r_tap_window;

    // input stage
    logic        r_in_vld;
    logic [2:0]  r_kind;
    logic [3:0]  r_button;
    logic [63:0] r_now;
    logic [3:0]  r_mods;
    logic        r_latch_value;

    // result stage
    logic        r_out_vld;
    t_result     r_res;
    logic [3:0]  r_button_out;
    logic [3:0]  r_mods_out;

    logic        advance;
    logic        slot_we;
    t_slot       rd_slot;
    t_slot       wr_slot;
    t_result     res;

    // input stage moves on when the result register is free or being drained
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_window <= MCT_TAP_WINDOW_RST;
        end else if (i_cfg_we) begin
            r_tap_window <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind        <= i_kind;
            r_button      <= i_button;
            r_now         <= i_now;
            r_mods        <= i_mods;
            r_latch_value <= i_latch_value;
        end
    end

    mct_slot_table #(
        .BUTTONS (BUTTONS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (r_button[IDX_W-1:0]),
        .o_rd_slot (rd_slot),
        .i_wr_en   (advance && slot_we),
        .i_wr_idx  (r_button[IDX_W-1:0]),
        .i_wr_slot (wr_slot)
    );

    mct_update #(
        .BUTTONS (BUTTONS)
    ) u_update (
        .i_kind        (r_kind),
        .i_button      (r_button),
        .i_now         (r_now),
        .i_mods        (r_mods),
        .i_latch_value (r_latch_value),
        .i_tap_window  (r_tap_window),
        .i_slot        (rd_slot),
        .o_slot        (wr_slot),
        .o_wr_en       (slot_we),
        .o_result      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res        <= res;
            r_button_out <= r_button;
            r_mods_out   <= r_mods;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_action_out  = r_res.action;
    assign o_button_out  = r_button_out;
    assign o_mods_out    = r_mods_out;
    assign o_tap_count   = r_res.tap_count;
    assign o_tap_phase   = r_res.tap_phase;
    assign o_is_pressed  = r_res.pressed;
    assign o_hold_now    = r_res.hold_now;
    assign o_last_hold   = r_res.last_hold;
    assign o_press_latch = r_res.press_latch;

    // a result leaves the input stage into the result register
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_vld)
        else $error("result register not loaded after advance");

    // a released button reports no running hold
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_res.pressed) |-> (r_res.hold_now == 64'd0))
        else $error("hold_now nonzero while released");

    // a fresh press is held and has just started
    a_down_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.action == ACT_DOWN)
            |-> (r_res.pressed && r_res.hold_now == 64'd0 && r_res.tap_count != 8'd0))
        else $error("inconsistent down result");

    // a release drops both held and latch
    a_up_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.action == ACT_UP) |-> (!r_res.pressed && !r_res.press_latch))
        else $error("inconsistent up result");

    // no taps means no phase
    a_phase_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.tap_count == 8'd0) |-> (r_res.tap_phase == PH_NONE))
        else $error("tap phase set with zero taps");

endmodule
